// ===== src/tsa_pkg.sv =====
package tsa_pkg;

    localparam int unsigned DATA_W = 64;
    localparam int unsigned DIV_STEPS = DATA_W;

    // type tags
    localparam logic [1:0] T_INT  = 2'd0;
    localparam logic [1:0] T_CHR  = 2'd1;
    localparam logic [1:0] T_BOOL = 2'd2;
    localparam logic [1:0] T_NONE = 2'd3;

    // error codes
    localparam logic [1:0] E_OK    = 2'd0;
    localparam logic [1:0] E_TYPE  = 2'd1;
    localparam logic [1:0] E_SHIFT = 2'd2;
    localparam logic [1:0] E_ZDIV  = 2'd3;

    // commands
    localparam logic [4:0] CMD_NEG     = 5'd0;
    localparam logic [4:0] CMD_NOT     = 5'd1;
    localparam logic [4:0] CMD_EQ      = 5'd2;
    localparam logic [4:0] CMD_NE      = 5'd3;
    localparam logic [4:0] CMD_ADD     = 5'd4;
    localparam logic [4:0] CMD_SUB     = 5'd5;
    localparam logic [4:0] CMD_MUL     = 5'd6;
    localparam logic [4:0] CMD_GT      = 5'd7;
    localparam logic [4:0] CMD_LT      = 5'd8;
    localparam logic [4:0] CMD_GE      = 5'd9;
    localparam logic [4:0] CMD_LE      = 5'd10;
    localparam logic [4:0] CMD_LAND    = 5'd11;
    localparam logic [4:0] CMD_LOR     = 5'd12;
    localparam logic [4:0] CMD_BAND    = 5'd13;
    localparam logic [4:0] CMD_BOR     = 5'd14;
    localparam logic [4:0] CMD_BXOR    = 5'd15;
    localparam logic [4:0] CMD_SHL     = 5'd16;
    localparam logic [4:0] CMD_SHR     = 5'd17;
    localparam logic [4:0] CMD_DIV     = 5'd18;
    localparam logic [4:0] CMD_MOD     = 5'd19;
    localparam logic [4:0] CMD_CTZ     = 5'd20;
    localparam logic [4:0] CMD_POPCNT  = 5'd21;
    localparam logic [4:0] CMD_CHR2INT = 5'd22;
    localparam logic [4:0] CMD_INT2CHR = 5'd23;

    typedef logic [DATA_W-1:0] word_t;

    // request as it travels down the divider chain
    typedef struct packed {
        logic [4:0] cmd;
        logic [1:0] rt;
        logic [1:0] err;
        word_t      rv;
        logic       q_neg;
        logic       r_neg;
        word_t      rem;
        word_t      quo;
        word_t      dsr;
    } pipe_t;

    function automatic word_t char_of(input word_t v);
        return {{(DATA_W-8){v[7]}}, v[7:0]};
    endfunction

    function automatic word_t norm(input logic [1:0] t, input word_t v);
        word_t r;
        r = v;
        if (t == T_CHR) r = char_of(v);
        else if (t == T_BOOL) r = {{(DATA_W-1){1'b0}}, (v != '0)};
        return r;
    endfunction

endpackage

// ===== src/tsa_front.sv =====
module tsa_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [4:0]          command,
    input  logic [1:0]          a_type,
    input  logic signed [63:0]  a_value,
    input  logic [1:0]          b_type,
    input  logic signed [63:0]  b_value,
    output logic                vld,
    output tsa_pkg::pipe_t      item
);
    import tsa_pkg::*;

    // stage 0: normalized operands
    logic       v0_reg;
    logic [4:0] cmd0_reg;
    logic [1:0] ta0_reg, tb0_reg;
    word_t      a0_reg, b0_reg;

    // stage 1: simple results, partial products, divider setup
    logic       v1_reg;
    pipe_t      p1_reg, p1_next;
    logic [63:0] pp_ll_reg, pp_ll_next;
    logic [31:0] pp_x_reg, pp_x_next;

    // stage 2
    logic       v2_reg;
    pipe_t      p2_reg, p2_next;

    logic ii, cc, bb;
    word_t a, b, lsb, abs_a, abs_b;
    logic [6:0] ctz;
    logic [5:0] sh;
    logic [63:0] pp_lh, pp_hl;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v0_reg <= in_valid;
            v1_reg <= v0_reg;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd0_reg  <= command;
            ta0_reg   <= a_type;
            tb0_reg   <= b_type;
            a0_reg    <= norm(a_type, a_value);
            b0_reg    <= norm(b_type, b_value);
            p1_reg    <= p1_next;
            pp_ll_reg <= pp_ll_next;
            pp_x_reg  <= pp_x_next;
            p2_reg    <= p2_next;
        end
    end

    always_comb
    begin
        a  = a0_reg;
        b  = b0_reg;
        ii = (ta0_reg == T_INT)  && (tb0_reg == T_INT);
        cc = (ta0_reg == T_CHR)  && (tb0_reg == T_CHR);
        bb = (ta0_reg == T_BOOL) && (tb0_reg == T_BOOL);

        // trailing zeros: isolate lowest set bit, encode its index
        lsb = a & (~a + 64'd1);
        ctz = '0;
        for (int j = 0; j < 64; j++)
        begin
            if (lsb[j]) ctz[5:0] = ctz[5:0] | 6'(j);
        end
        if (a == '0) ctz = 7'd64;

        sh    = (b[63:6] != '0) ? 6'd63 : b[5:0];
        abs_a = a[63] ? (~a + 64'd1) : a;
        abs_b = b[63] ? (~b + 64'd1) : b;

        pp_ll_next = {32'b0, a[31:0]} * {32'b0, b[31:0]};
        pp_lh      = {32'b0, a[31:0]} * {32'b0, b[63:32]};
        pp_hl      = {32'b0, a[63:32]} * {32'b0, b[31:0]};
        pp_x_next  = pp_lh[31:0] + pp_hl[31:0];

        p1_next       = '0;
        p1_next.cmd   = cmd0_reg;
        p1_next.rt    = T_INT;
        p1_next.err   = E_OK;
        p1_next.q_neg = a[63] ^ b[63];
        p1_next.r_neg = a[63];
        p1_next.quo   = abs_a;
        p1_next.dsr   = abs_b;

        case (cmd0_reg)
            CMD_NEG:
                if (ta0_reg == T_INT) p1_next.rv = ~a + 64'd1;
                else p1_next.err = E_TYPE;
            CMD_NOT:
                if (ta0_reg == T_BOOL)
                begin
                    p1_next.rt = T_BOOL;
                    p1_next.rv = a ^ 64'd1;
                end
                else p1_next.err = E_TYPE;
            CMD_EQ, CMD_NE:
                if (ta0_reg == T_NONE || tb0_reg == T_NONE) p1_next.err = E_TYPE;
                else
                begin
                    p1_next.rt = T_BOOL;
                    p1_next.rv = {63'b0, ((ta0_reg == tb0_reg) && (a == b))
                                         ^ (cmd0_reg == CMD_NE)};
                end
            CMD_ADD, CMD_SUB:
                if (ii) p1_next.rv = (cmd0_reg == CMD_ADD) ? a + b : a - b;
                else if (ta0_reg == T_CHR && tb0_reg == T_INT)
                begin
                    p1_next.rt = T_CHR;
                    p1_next.rv = char_of((cmd0_reg == CMD_ADD) ? a + b : a - b);
                end
                else if (cmd0_reg == CMD_SUB && cc) p1_next.rv = a - b;
                else p1_next.err = E_TYPE;
            CMD_MUL:
                if (!ii) p1_next.err = E_TYPE;
            CMD_GT, CMD_LT, CMD_GE, CMD_LE:
                if (!ii && !cc) p1_next.err = E_TYPE;
                else
                begin
                    p1_next.rt = T_BOOL;
                    case (cmd0_reg)
                        CMD_GT:  p1_next.rv[0] = $signed(a) > $signed(b);
                        CMD_LT:  p1_next.rv[0] = $signed(a) < $signed(b);
                        CMD_GE:  p1_next.rv[0] = $signed(a) >= $signed(b);
                        default: p1_next.rv[0] = $signed(a) <= $signed(b);
                    endcase
                end
            CMD_LAND, CMD_LOR:
                if (!bb) p1_next.err = E_TYPE;
                else
                begin
                    p1_next.rt = T_BOOL;
                    p1_next.rv = (cmd0_reg == CMD_LAND) ? (a & b) : (a | b);
                end
            CMD_BAND:
                if (ii) p1_next.rv = a & b; else p1_next.err = E_TYPE;
            CMD_BOR:
                if (ii) p1_next.rv = a | b; else p1_next.err = E_TYPE;
            CMD_BXOR:
                if (ii) p1_next.rv = a ^ b; else p1_next.err = E_TYPE;
            CMD_SHL, CMD_SHR:
                if (!ii) p1_next.err = E_TYPE;
                else if (b[63]) p1_next.err = E_SHIFT;
                else if (cmd0_reg == CMD_SHL)
                    p1_next.rv = (b[63:6] != '0) ? '0 : (a << b[5:0]);
                else
                    p1_next.rv = word_t'($signed(a) >>> sh);
            CMD_DIV, CMD_MOD:
                if (!ii) p1_next.err = E_TYPE;
                else if (b == '0) p1_next.err = E_ZDIV;
            CMD_CTZ:
                if (ta0_reg == T_INT) p1_next.rv = {57'b0, ctz};
                else p1_next.err = E_TYPE;
            CMD_POPCNT:
                if (ta0_reg == T_INT) p1_next.rv = 64'($countones(a));
                else p1_next.err = E_TYPE;
            CMD_CHR2INT:
                if (ta0_reg == T_CHR) p1_next.rv = a;
                else p1_next.err = E_TYPE;
            CMD_INT2CHR:
                if (ta0_reg == T_INT)
                begin
                    p1_next.rt = T_CHR;
                    p1_next.rv = char_of(a);
                end
                else p1_next.err = E_TYPE;
            default:
                p1_next.err = E_TYPE;
        endcase
    end

    // stage 2: finish the low half of the product
    always_comb
    begin
        p2_next = p1_reg;
        if (p1_reg.cmd == CMD_MUL)
            p2_next.rv = pp_ll_reg + {pp_x_reg, 32'b0};
    end

    assign vld  = v2_reg;
    assign item = p2_reg;

endmodule

// ===== src/tsa_div_step.sv =====
module tsa_div_step (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  tsa_pkg::pipe_t in_item,
    output logic           out_vld,
    output tsa_pkg::pipe_t out_item
);
    import tsa_pkg::*;

    logic  vld_reg;
    pipe_t item_reg, item_next;
    logic [DATA_W:0] trial, diff;

    // one quotient bit: shift in the next dividend bit, subtract if it fits
    always_comb
    begin
        item_next = in_item;
        trial     = {in_item.rem, in_item.quo[DATA_W-1]};
        diff      = trial - {1'b0, in_item.dsr};
        if (!diff[DATA_W])
        begin
            item_next.rem = diff[DATA_W-1:0];
            item_next.quo = {in_item.quo[DATA_W-2:0], 1'b1};
        end
        else
        begin
            item_next.rem = trial[DATA_W-1:0];
            item_next.quo = {in_item.quo[DATA_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) vld_reg <= 1'b0;
        else if (en) vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en) item_reg <= item_next;
    end

    assign out_vld  = vld_reg;
    assign out_item = item_reg;

endmodule

// ===== src/tsa_back.sv =====
module tsa_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_vld,
    input  tsa_pkg::pipe_t in_item,
    output logic           valid,
    output logic [1:0]     result_type,
    output logic signed [63:0] result_value,
    output logic [1:0]     error_code
);
    import tsa_pkg::*;

    logic       valid_reg;
    logic [1:0] rt_reg, rt_next, err_reg;
    word_t      rv_reg, rv_next;

    always_comb
    begin
        rt_next = in_item.rt;
        rv_next = in_item.rv;
        if (in_item.cmd == CMD_DIV)
            rv_next = in_item.q_neg ? (~in_item.quo + 64'd1) : in_item.quo;
        else if (in_item.cmd == CMD_MOD)
            rv_next = in_item.r_neg ? (~in_item.rem + 64'd1) : in_item.rem;
        if (in_item.err != E_OK)
        begin
            rt_next = T_INT;
            rv_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else if (en) valid_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_reg  <= rt_next;
            rv_reg  <= rv_next;
            err_reg <= in_item.err;
        end
    end

    assign valid        = valid_reg;
    assign result_type  = rt_reg;
    assign result_value = rv_reg;
    assign error_code   = err_reg;

endmodule

// ===== src/tagged_scalar_alu.sv =====
// tagged_scalar_alu: type-tagged scalar alu for an interpreter
//
// request side: in_valid / in_stall with command, a_type, a_value, b_type,
// b_value; a request is taken at a clock edge with in_valid high and in_stall low
// result side: out_valid / out_stall with result_type, result_value, error_code;
// every request gives exactly one result, in request order
//
// path from accepted request to result on the ports:
//   front end: operand normalize, simple ops and split 64x64 multiply,
//   restoring divider (one quotient bit per stage),
//   sign fix and output register
// all requests travel the same depth, so order is kept by construction
// throughput: one request per cycle while the result side takes results
//
// the whole pipe moves on one enable; while a result sits stalled in the
// output register the pipe holds and in_stall is raised, nothing is lost
// reset: asynchronous, active low, clears all valid bits; the pipe is empty
module tagged_scalar_alu (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [4:0]         command,
    input  logic [1:0]         a_type,
    input  logic signed [63:0] a_value,
    input  logic [1:0]         b_type,
    input  logic signed [63:0] b_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         result_type,
    output logic signed [63:0] result_value,
    output logic [1:0]         error_code
);
    import tsa_pkg::*;

    logic  en;
    logic  vld [0:DIV_STEPS];
    pipe_t item [0:DIV_STEPS];

    // pipe advances unless a result is waiting and being stalled
    assign en       = !out_valid || !out_stall;
    assign in_stall = !en;

    tsa_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_valid),
        .command  (command),
        .a_type   (a_type),
        .a_value  (a_value),
        .b_type   (b_type),
        .b_value  (b_value),
        .vld      (vld[0]),
        .item     (item[0])
    );

    // divider chain, one quotient bit per stage
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        tsa_div_step u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (en),
            .in_vld   (vld[i]),
            .in_item  (item[i]),
            .out_vld  (vld[i+1]),
            .out_item (item[i+1])
        );
    end

    tsa_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_vld       (vld[DIV_STEPS]),
        .in_item      (item[DIV_STEPS]),
        .valid        (out_valid),
        .result_type  (result_type),
        .result_value (result_value),
        .error_code   (error_code)
    );

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps

// request-level check of tagged_scalar_alu: a queue-fed driver sends tagged
// requests with random idle bursts, a monitor takes results under random
// stall bursts and compares them in order with a predicted result queue
module testbench;
    import tsa_pkg::*;

    typedef struct {
        logic [4:0]  cmd;
        logic [1:0]  ta;
        logic [63:0] av;
        logic [1:0]  tb;
        logic [63:0] bv;
    } alu_req_t;

    typedef struct {
        logic [1:0]  rt;
        logic [63:0] rv;
        logic [1:0]  err;
    } alu_res_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [4:0]         command;
    logic [1:0]         a_type;
    logic signed [63:0] a_value;
    logic [1:0]         b_type;
    logic signed [63:0] b_value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         result_type;
    logic signed [63:0] result_value;
    logic [1:0]         error_code;

    alu_req_t pending_reqs[$];
    alu_res_t expected_results[$];
    int       mismatches;
    bit       calm;      // no idling in the last part of the run
    int       send_gap;
    int       stall_left;
    bit       in_taken;  // request was accepted at the last rising edge

    tagged_scalar_alu u_top (.*);

    // clock: period 10 ns
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // local view of an operand after its tag is applied
    function automatic logic [63:0] tag_value(logic [1:0] t, logic [63:0] v);
        if (t == T_CHR)
            return {{56{v[7]}}, v[7:0]};
        if (t == T_BOOL)
            return (v != 64'd0) ? 64'd1 : 64'd0;
        return v;
    endfunction

    function automatic alu_res_t alu_predict(alu_req_t q);
        alu_res_t r;
        logic [63:0] a, b, t;
        logic signed [63:0] sa, sb;
        bit ii, cc, bb, c;
        int n;
        a = tag_value(q.ta, q.av);
        b = tag_value(q.tb, q.bv);
        sa = a;
        sb = b;
        ii = (q.ta == T_INT) && (q.tb == T_INT);
        cc = (q.ta == T_CHR) && (q.tb == T_CHR);
        bb = (q.ta == T_BOOL) && (q.tb == T_BOOL);
        r.rt = T_INT;
        r.rv = 64'd0;
        r.err = E_OK;
        case (q.cmd)
            CMD_NEG:
                if (q.ta == T_INT) r.rv = -a; else r.err = E_TYPE;
            CMD_NOT:
                if (q.ta == T_BOOL)
                begin
                    r.rt = T_BOOL;
                    r.rv = a ^ 64'd1;
                end
                else
                    r.err = E_TYPE;
            CMD_EQ, CMD_NE:
                if (q.ta == T_NONE || q.tb == T_NONE)
                    r.err = E_TYPE;
                else
                begin
                    r.rt = T_BOOL;
                    c = (q.ta == q.tb) && (a == b);
                    r.rv = (c ^ (q.cmd == CMD_NE)) ? 64'd1 : 64'd0;
                end
            CMD_ADD, CMD_SUB:
            begin
                t = (q.cmd == CMD_ADD) ? a + b : a - b;
                if (ii)
                    r.rv = t;
                else if (q.ta == T_CHR && q.tb == T_INT)
                begin
                    r.rt = T_CHR;
                    r.rv = {{56{t[7]}}, t[7:0]};
                end
                else if (q.cmd == CMD_SUB && cc)
                    r.rv = t;
                else
                    r.err = E_TYPE;
            end
            CMD_MUL:
                if (ii) r.rv = a * b; else r.err = E_TYPE;
            CMD_GT, CMD_LT, CMD_GE, CMD_LE:
                if (!ii && !cc)
                    r.err = E_TYPE;
                else
                begin
                    case (q.cmd)
                        CMD_GT: c = sa > sb;
                        CMD_LT: c = sa < sb;
                        CMD_GE: c = sa >= sb;
                        default: c = sa <= sb;
                    endcase
                    r.rt = T_BOOL;
                    r.rv = c ? 64'd1 : 64'd0;
                end
            CMD_LAND, CMD_LOR:
                if (!bb)
                    r.err = E_TYPE;
                else
                begin
                    r.rt = T_BOOL;
                    r.rv = (q.cmd == CMD_LAND) ? (a & b) : (a | b);
                end
            CMD_BAND:
                if (ii) r.rv = a & b; else r.err = E_TYPE;
            CMD_BOR:
                if (ii) r.rv = a | b; else r.err = E_TYPE;
            CMD_BXOR:
                if (ii) r.rv = a ^ b; else r.err = E_TYPE;
            CMD_SHL, CMD_SHR:
                if (!ii)
                    r.err = E_TYPE;
                else if (sb < 0)
                    r.err = E_SHIFT;
                else if (q.cmd == CMD_SHL)
                    r.rv = (b >= 64) ? 64'd0 : (a << b[5:0]);
                else
                    r.rv = sa >>> ((b >= 64) ? 6'd63 : b[5:0]);
            CMD_DIV, CMD_MOD:
                if (!ii)
                    r.err = E_TYPE;
                else if (b == 64'd0)
                    r.err = E_ZDIV;
                else if (a == 64'h8000_0000_0000_0000 && sb == -1)
                    r.rv = (q.cmd == CMD_DIV) ? a : 64'd0;
                else
                    r.rv = (q.cmd == CMD_DIV) ? sa / sb : sa % sb;
            CMD_CTZ:
                if (q.ta == T_INT)
                begin
                    n = 64;
                    for (int i = 63; i >= 0; i--)
                        if (a[i]) n = i;
                    r.rv = 64'(n);
                end
                else
                    r.err = E_TYPE;
            CMD_POPCNT:
                if (q.ta == T_INT) r.rv = 64'($countones(a)); else r.err = E_TYPE;
            CMD_CHR2INT:
                if (q.ta == T_CHR) r.rv = a; else r.err = E_TYPE;
            CMD_INT2CHR:
                if (q.ta == T_INT)
                begin
                    r.rt = T_CHR;
                    r.rv = {{56{a[7]}}, a[7:0]};
                end
                else
                    r.err = E_TYPE;
            default:
                r.err = E_TYPE;
        endcase
        if (r.err != E_OK)
        begin
            r.rt = T_INT;
            r.rv = 64'd0;
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic queue_req(logic [4:0] cmd, logic [1:0] ta, logic [63:0] av,
                             logic [1:0] tb, logic [63:0] bv);
        alu_req_t q;
        q.cmd = cmd;
        q.ta = ta;
        q.av = av;
        q.tb = tb;
        q.bv = bv;
        pending_reqs = {pending_reqs, q};
    endtask

    // operand values biased toward edges, small counts and char range
    function automatic logic [63:0] pick_value();
        case ($urandom_range(0, 7))
            0: return {$urandom, $urandom} & 64'h8000_0000_0000_0000;
            1: return 64'h7FFF_FFFF_FFFF_FFFF;
            2: return 64'hFFFF_FFFF_FFFF_FFFF;
            3: return 64'($urandom_range(0, 70));
            4: return -64'($urandom_range(0, 70));
            5: return {{56{1'b0}}, 8'($urandom)};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // acceptance as seen at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_taken <= 1'b0;
        else
            in_taken <= in_valid && !in_stall;
    end

    // driver: a request stays on the ports until it is taken
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (!in_valid || in_taken)
        begin
            if (send_gap > 0)
            begin
                in_valid <= 1'b0;
                send_gap <= send_gap - 1;
            end
            else if (pending_reqs.size() > 0)
            begin
                alu_req_t q;
                q = pending_reqs.pop_front();
                in_valid <= 1'b1;
                command <= q.cmd;
                a_type <= q.ta;
                a_value <= q.av;
                b_type <= q.tb;
                b_value <= q.bv;
                expected_results = {expected_results, alu_predict(q)};
                // idle burst now and then, none in the calm tail
                if (!calm && $urandom_range(0, 9) == 0)
                    send_gap <= $urandom_range(1, 9);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // result side stall bursts
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (!calm && $urandom_range(0, 11) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 8);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: compare each taken result with the oldest prediction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            alu_res_t e;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", result_value, 64'd0);
            else
            begin
                e = expected_results.pop_front();
                if (result_type !== e.rt)
                    report_mismatch("result_type", {62'b0, result_type}, {62'b0, e.rt});
                if (result_value !== e.rv)
                    report_mismatch("result_value", result_value, e.rv);
                if (error_code !== e.err)
                    report_mismatch("error_code", {62'b0, error_code}, {62'b0, e.err});
            end
        end
    end

    initial
    begin
        logic [4:0] cmd;
        logic [1:0] ta, tb;
        int wait_cycles;
        in_valid = 1'b0;
        out_stall = 1'b0;
        command = '0;
        a_type = '0;
        a_value = '0;
        b_type = '0;
        b_value = '0;
        mismatches = 0;
        calm = 1'b0;
        rst_n = 1'b0;

        // directed: edges, cross-type equality, wraps, shifts, division corners
        queue_req(CMD_NEG, T_INT, 64'h8000_0000_0000_0000, T_INT, 0);
        queue_req(CMD_NOT, T_BOOL, 64'h0000_0100_0000_0000, T_INT, 0);
        queue_req(CMD_EQ, T_INT, 1, T_BOOL, 1);
        queue_req(CMD_EQ, T_CHR, 64'h0000_0000_0000_01FF, T_CHR, -1);
        queue_req(CMD_NE, T_NONE, 0, T_NONE, 0);
        queue_req(CMD_ADD, T_CHR, 127, T_INT, 1);
        queue_req(CMD_SUB, T_CHR, -128, T_CHR, 127);
        queue_req(CMD_SUB, T_INT, 64'h8000_0000_0000_0000, T_INT, 1);
        queue_req(CMD_MUL, T_INT, 64'h7FFF_FFFF_FFFF_FFFF, T_INT, -1);
        queue_req(CMD_GT, T_CHR, 8'h80, T_CHR, 1);
        queue_req(CMD_LE, T_INT, -5, T_INT, -5);
        queue_req(CMD_LAND, T_BOOL, 2, T_BOOL, 64'h8000_0000_0000_0000);
        queue_req(CMD_SHL, T_INT, 1, T_INT, 64);
        queue_req(CMD_SHL, T_INT, 1, T_INT, -1);
        queue_req(CMD_SHR, T_INT, 64'h8000_0000_0000_0000, T_INT, 200);
        queue_req(CMD_SHR, T_INT, -7, T_INT, 0);
        queue_req(CMD_DIV, T_INT, 64'h8000_0000_0000_0000, T_INT, -1);
        queue_req(CMD_MOD, T_INT, 64'h8000_0000_0000_0000, T_INT, -1);
        queue_req(CMD_MOD, T_INT, -7, T_INT, 2);
        queue_req(CMD_DIV, T_INT, 5, T_INT, 0);
        queue_req(CMD_CTZ, T_INT, 0, T_INT, 0);
        queue_req(CMD_POPCNT, T_INT, -1, T_INT, 0);
        queue_req(CMD_CHR2INT, T_CHR, 64'hFFFF_FFFF_FFFF_FF80, T_INT, 0);
        queue_req(CMD_INT2CHR, T_INT, 64'h1234_5678_9ABC_DEFF, T_INT, 0);
        queue_req(5'd31, T_INT, 0, T_INT, 0);

        // random: mostly well-typed requests, some any-tag noise
        for (int i = 0; i < 500; i++)
        begin
            cmd = (i % 10 == 0) ? 5'($urandom) : 5'($urandom_range(0, 23));
            ta = 2'($urandom_range(0, 2));
            tb = ta;
            if ($urandom_range(0, 4) == 0)
            begin
                ta = 2'($urandom);
                tb = 2'($urandom);
            end
            else if (cmd inside {CMD_ADD, CMD_SUB} && $urandom_range(0, 2) == 0)
            begin
                ta = T_CHR;
                tb = T_INT;
            end
            queue_req(cmd, ta, pick_value(), tb, pick_value());
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // last stretch runs with no idling on either side
        wait (pending_reqs.size() < 60);
        calm = 1'b1;
        wait (pending_reqs.size() == 0 && expected_results.size() == 0);
        wait_cycles = 0;
        while (wait_cycles < 80)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // run limit
    initial
    begin
        #2ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tsa_pkg.sv
src/tsa_front.sv
src/tsa_div_step.sv
src/tsa_back.sv
src/tagged_scalar_alu.sv
dv/testbench.sv
